// File: rtl/core/bfie_pkg.sv
package bfie_pkg;

    localparam int BITS_PER_BYTE   = 8;
    localparam int DEF_BUF_BYTES   = 64;
    localparam int MAX_FIELD_BITS  = 64;

    localparam int MODE_W  = 1;
    localparam int START_W = 9;
    localparam int COUNT_W = 7;
    localparam int DATA_W  = 64;

    // The buffer is held as rows of 64 bits, split into an even and an odd bank.
    localparam int ROW_BITS = 64;
    localparam int OFF_W    = 6;
    localparam int ROW_W    = START_W - OFF_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 1'b0,
        MODE_READ  = 1'b1
    } mode_t;

endpackage

// File: rtl/core/bit_field_insert_extract.sv
// Bit field insert/extract engine over a cleared byte buffer.
// Input channel (in_valid/in_ready) carries one request word: mode, bit_start,
// bit_count and data_in. A write copies the low bit_count bits of data_in into
// the buffer from bit bit_start on; a read returns that many bits in read_data.
// Bit n of the buffer is bit n%8 of byte n/8. Counts above 64 are treated as 64.
// A request that runs past the end of the buffer sets range_error and changes
// nothing.
// Output channel (out_valid/out_ready) returns one result word per request.
// out_valid rises once the request has passed the input stage and the result
// register loads from it. The buffer rows are read into the input stage at
// acceptance, then merged or extracted and written back as the result register
// loads. Throughput is one request per cycle while the receiver takes results.
// Back-to-back requests to the same row are forwarded from the write port.
// At reset every row is marked empty at once and reads back as zero, so the
// buffer is clear without a sweep. When the receiver stalls, the result register
// holds, one more request is still taken into the input stage, and in_ready then
// drops until the result is taken.
module bit_field_insert_extract
    import bfie_pkg::*;
#(
    parameter int BUF_BYTES = DEF_BUF_BYTES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MODE_W-1:0]   mode,
    input  logic [START_W-1:0]  bit_start,
    input  logic [COUNT_W-1:0]  bit_count,
    input  logic [DATA_W-1:0]   data_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DATA_W-1:0]   read_data,
    output logic [COUNT_W-1:0]  bits_done,
    output logic                range_error
);

    localparam int TOTAL_BITS = BUF_BYTES * BITS_PER_BYTE;
    localparam int ROWS       = (TOTAL_BITS + ROW_BITS - 1) / ROW_BITS;
    localparam int BANK_ROWS  = (ROWS + 1) / 2;
    localparam int BANK_AW    = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
    localparam int EXT_W      = (BANK_AW > ROW_W) ? BANK_AW : ROW_W;

    // Buffer storage
    logic [ROW_BITS-1:0]  even_mem [BANK_ROWS];
    logic [ROW_BITS-1:0]  odd_mem  [BANK_ROWS];
    logic [BANK_ROWS-1:0] even_vld_reg;
    logic [BANK_ROWS-1:0] odd_vld_reg;

    // Input stage
    logic                 s1_valid_reg;
    logic                 s1_write_reg;
    logic [OFF_W-1:0]     s1_off_reg;
    logic [COUNT_W-1:0]   s1_cnt_reg;
    logic                 s1_err_reg;
    logic                 s1_lo_odd_reg;
    logic [DATA_W-1:0]    s1_data_reg;
    logic [EXT_W-1:0]     s1_even_addr_reg;
    logic [EXT_W-1:0]     s1_odd_addr_reg;
    logic                 s1_even_in_reg;
    logic                 s1_odd_in_reg;
    logic [ROW_BITS-1:0]  even_rd_reg;
    logic [ROW_BITS-1:0]  odd_rd_reg;

    // Result register
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    read_data_reg;
    logic [COUNT_W-1:0]   bits_done_reg;
    logic                 range_error_reg;

    logic                 in_accept;
    logic                 s1_adv;
    logic                 s1_fire;

    logic [COUNT_W-1:0]   cnt_sat;
    logic [START_W:0]     end_pos;
    logic                 req_err;
    logic [ROW_W:0]       row_lo;
    logic [ROW_W:0]       row_lo_inc;
    logic [EXT_W-1:0]     ra_even;
    logic [EXT_W-1:0]     ra_odd;
    logic                 ra_even_in;
    logic                 ra_odd_in;

    logic [DATA_W-1:0]      field_mask;
    logic [2*ROW_BITS-1:0]  window;
    logic [2*ROW_BITS-1:0]  win_mask;
    logic [2*ROW_BITS-1:0]  win_data;
    logic [2*ROW_BITS-1:0]  new_window;
    logic [2*ROW_BITS-1:0]  win_shifted;
    logic [DATA_W-1:0]      extract;
    logic                   wr_en;
    logic                   even_we;
    logic                   odd_we;
    logic [ROW_BITS-1:0]    even_wd;
    logic [ROW_BITS-1:0]    odd_wd;

    assign s1_adv    = !out_valid_reg || out_ready;
    assign s1_fire   = s1_valid_reg && s1_adv;
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;

    // Request decode ahead of the input stage: saturation, range check, row addresses.
    always_comb
    begin
        cnt_sat = (bit_count > COUNT_W'(MAX_FIELD_BITS)) ? COUNT_W'(MAX_FIELD_BITS)
                                                           : bit_count;
        end_pos = {1'b0, bit_start} + (START_W + 1)'(cnt_sat);
        req_err = 32'(end_pos) > TOTAL_BITS;
        row_lo     = {1'b0, bit_start[START_W-1:OFF_W]};
        row_lo_inc = row_lo + (ROW_W + 1)'(1);
        // The low row sits in the odd bank when its index is odd; the other bank
        // then holds the row above it.
        ra_even    = EXT_W'(row_lo_inc[ROW_W:1]);
        ra_odd     = EXT_W'(row_lo[ROW_W:1]);
        ra_even_in = 32'(ra_even) < BANK_ROWS;
        ra_odd_in  = 32'(ra_odd) < BANK_ROWS;
    end

    // Merge and extract over the two-row window.
    always_comb
    begin
        field_mask = s1_cnt_reg[COUNT_W-1] ? {DATA_W{1'b1}}
                   : ((DATA_W'(1) << s1_cnt_reg[OFF_W-1:0]) - DATA_W'(1));
        window     = s1_lo_odd_reg ? {even_rd_reg, odd_rd_reg} : {odd_rd_reg, even_rd_reg};
        win_shifted = window >> s1_off_reg;
        extract    = win_shifted[DATA_W-1:0] & field_mask;
        win_mask   = {{ROW_BITS{1'b0}}, field_mask} << s1_off_reg;
        win_data   = {{ROW_BITS{1'b0}}, s1_data_reg & field_mask} << s1_off_reg;
        new_window = (window & ~win_mask) | win_data;
        even_wd    = s1_lo_odd_reg ? new_window[2*ROW_BITS-1:ROW_BITS]
                                   : new_window[ROW_BITS-1:0];
        odd_wd     = s1_lo_odd_reg ? new_window[ROW_BITS-1:0]
                                   : new_window[2*ROW_BITS-1:ROW_BITS];
        wr_en      = s1_fire && s1_write_reg && !s1_err_reg && (s1_cnt_reg != '0);
        even_we    = wr_en && s1_even_in_reg;
        odd_we     = wr_en && s1_odd_in_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            even_vld_reg  <= '0;
            odd_vld_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (even_we)
            begin
                even_vld_reg[s1_even_addr_reg[BANK_AW-1:0]] <= 1'b1;
            end
            if (odd_we)
            begin
                odd_vld_reg[s1_odd_addr_reg[BANK_AW-1:0]] <= 1'b1;
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Buffer banks: write-back of the finishing word, and the row read of the new
    // word with the write forwarded when both hit the same row.
    always_ff @(posedge clk)
    begin
        if (even_we)
        begin
            even_mem[s1_even_addr_reg[BANK_AW-1:0]] <= even_wd;
        end
        if (odd_we)
        begin
            odd_mem[s1_odd_addr_reg[BANK_AW-1:0]] <= odd_wd;
        end
        if (in_accept)
        begin
            if (!ra_even_in)
                even_rd_reg <= '0;
            else if (even_we && (s1_even_addr_reg == ra_even))
                even_rd_reg <= even_wd;
            else if (even_vld_reg[ra_even[BANK_AW-1:0]])
                even_rd_reg <= even_mem[ra_even[BANK_AW-1:0]];
            else
                even_rd_reg <= '0;

            if (!ra_odd_in)
                odd_rd_reg <= '0;
            else if (odd_we && (s1_odd_addr_reg == ra_odd))
                odd_rd_reg <= odd_wd;
            else if (odd_vld_reg[ra_odd[BANK_AW-1:0]])
                odd_rd_reg <= odd_mem[ra_odd[BANK_AW-1:0]];
            else
                odd_rd_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_write_reg     <= (mode == MODE_WRITE);
            s1_off_reg       <= bit_start[OFF_W-1:0];
            s1_cnt_reg       <= cnt_sat;
            s1_err_reg       <= req_err;
            s1_lo_odd_reg    <= bit_start[OFF_W];
            s1_data_reg      <= data_in;
            s1_even_addr_reg <= ra_even;
            s1_odd_addr_reg  <= ra_odd;
            s1_even_in_reg   <= ra_even_in;
            s1_odd_in_reg    <= ra_odd_in;
        end
        if (s1_fire)
        begin
            read_data_reg   <= (!s1_write_reg && !s1_err_reg) ? extract : '0;
            bits_done_reg   <= s1_err_reg ? '0 : s1_cnt_reg;
            range_error_reg <= s1_err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign bits_done   = bits_done_reg;
    assign range_error = range_error_reg;

endmodule
